### rtl/core/assert_macros.svh
// Assertion macros shared by the hex color parser RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HCLP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");

// Expression that must never be true outside reset.
`define HCLP_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`endif

### rtl/core/hclp_pkg.sv
// Package for the hex color literal parser: types, constants, character classes.
// No dependencies.
`default_nettype none

package hclp_pkg;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_AFTER = 2'd2,
		PH_NOTSH = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FORMAT  = 2'd2,
		ST_BADCHAR = 2'd3
	} status_t;

	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 4;
	localparam int NIB_W   = 32;
	localparam int CHAN_W  = 8;

	localparam logic [CHAR_W-1:0]  HASH_CHAR     = 8'h23;
	localparam logic [COUNT_W-1:0] DIGITS_MAX    = 4'd15;
	localparam logic [CHAN_W-1:0]  ALPHA_DEFAULT = 8'hFF;

	localparam logic [COUNT_W-1:0] LEN_RGB      = 4'd3;
	localparam logic [COUNT_W-1:0] LEN_RGBA     = 4'd4;
	localparam logic [COUNT_W-1:0] LEN_RRGGBB   = 4'd6;
	localparam logic [COUNT_W-1:0] LEN_RRGGBBAA = 4'd8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Scan state of one finished string, handed from front to back.
	typedef struct packed {
		phase_t              phase;
		logic [COUNT_W-1:0]  digit_count;
		logic [NIB_W-1:0]    nibbles;
		logic                bad_char;
	} scan_rec_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_dec_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		logic r;
		r = 1'b0;
		case (c) inside
			8'd32, [8'd9:8'd13]: r = 1'b1;
			default:             r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic hex_dec_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_dec_t   d;
		logic [7:0] t;
		d = '0;
		t = '0;
		case (c) inside
			[8'h30:8'h39]: begin
				t = c - 8'h30;
				d = '{valid: 1'b1, value: t[3:0]};
			end
			[8'h41:8'h46]: begin
				t = c - 8'h37;
				d = '{valid: 1'b1, value: t[3:0]};
			end
			[8'h61:8'h66]: begin
				t = c - 8'h57;
				d = '{valid: 1'b1, value: t[3:0]};
			end
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/core/hclp_front.sv
// Front end: accepts characters, tracks the scan state, pushes one record per string.
// Depends on hclp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hclp_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output      logic                      in_stall,
	input  wire logic [hclp_pkg::CHAR_W-1:0] char_code,
	input  wire logic                      has_char,
	input  wire logic                      last,
	output      logic                      push,
	output      hclp_pkg::scan_rec_t       push_rec,
	input  wire logic                      full
);
	import hclp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [NIB_W-1:0]   nib_q, nib_d;
	logic               bad_q, bad_d;
	logic               accept;
	hex_dec_t           hex;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept && last;
	assign hex      = hex_decode(char_code);

	assign push_rec = '{phase: phase_d, digit_count: count_d, nibbles: nib_d,
		bad_char: bad_d};

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		nib_d   = nib_q;
		bad_d   = bad_q;
		if (has_char) begin
			case (phase_q)
				PH_LEAD: begin
					if (!is_space(char_code))
						phase_d = (char_code == HASH_CHAR) ? PH_TOKEN : PH_NOTSH;
				end
				PH_TOKEN: begin
					if (is_space(char_code)) begin
						phase_d = PH_AFTER;
					end else begin
						if (hex.valid)
							nib_d = {nib_q[NIB_W-5:0], hex.value};
						else
							bad_d = 1'b1;
						if (count_q != DIGITS_MAX)
							count_d = count_q + COUNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// State clears after the end-of-string transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			count_q <= '0;
			nib_q   <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_LEAD;
				count_q <= '0;
				nib_q   <= '0;
				bad_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				count_q <= count_d;
				nib_q   <= nib_d;
				bad_q   <= bad_d;
			end
		end
	end

	`HCLP_ASSERT(a_clear_after_push,
		push |=> (phase_q == PH_LEAD && count_q == '0 && !bad_q))
	`HCLP_ASSERT(a_bad_only_in_token,
		bad_q |-> (phase_q == PH_TOKEN || phase_q == PH_AFTER))

endmodule

`default_nettype wire

### rtl/core/hclp_queue.sv
// Short register queue of scan records between front and back.
// Depends on hclp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hclp_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire hclp_pkg::scan_rec_t push_rec,
	output      logic                full,
	input  wire logic                pop,
	output      hclp_pkg::scan_rec_t pop_rec,
	output      logic                empty
);
	import hclp_pkg::*;

	scan_rec_t           slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] fill_q;

	assign full    = (fill_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign pop_rec = slot_q[rd_ptr_q];

	function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
		return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + QUEUE_CW'(1);
			else if (pop && !push)
				fill_q <= fill_q - QUEUE_CW'(1);
		end
	end

	`HCLP_NEVER(a_no_overflow, push && full)
	`HCLP_NEVER(a_no_underflow, pop && empty)

endmodule

`default_nettype wire

### rtl/core/hclp_back.sv
// Back end: turns a scan record into status and channel values, holds the output register.
// Depends on hclp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hclp_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      empty,
	input  wire hclp_pkg::scan_rec_t       pop_rec,
	output      logic                      pop,
	output      logic                      out_valid,
	input  wire logic                      out_stall,
	output      logic [1:0]                status,
	output      logic [hclp_pkg::CHAN_W-1:0] red,
	output      logic [hclp_pkg::CHAN_W-1:0] green,
	output      logic [hclp_pkg::CHAN_W-1:0] blue,
	output      logic [hclp_pkg::CHAN_W-1:0] alpha
);
	import hclp_pkg::*;

	logic              out_valid_q;
	status_t           status_q, status_d;
	logic [CHAN_W-1:0] red_q, green_q, blue_q, alpha_q;
	logic [CHAN_W-1:0] red_d, green_d, blue_d, alpha_d;
	logic [NIB_W-1:0]  n;

	assign n   = pop_rec.nibbles;
	assign pop = !empty && (!out_valid_q || !out_stall);

	// Short forms repeat each nibble, which is the same as times 17.
	always_comb begin
		status_d = ST_OK;
		red_d    = '0;
		green_d  = '0;
		blue_d   = '0;
		alpha_d  = '0;
		if (pop_rec.phase == PH_LEAD) begin
			status_d = ST_EMPTY;
		end else if (pop_rec.phase == PH_NOTSH) begin
			status_d = ST_FORMAT;
		end else if (pop_rec.bad_char) begin
			status_d = ST_BADCHAR;
		end else begin
			case (pop_rec.digit_count)
				LEN_RGB: begin
					red_d   = {n[11:8], n[11:8]};
					green_d = {n[7:4], n[7:4]};
					blue_d  = {n[3:0], n[3:0]};
					alpha_d = ALPHA_DEFAULT;
				end
				LEN_RGBA: begin
					red_d   = {n[15:12], n[15:12]};
					green_d = {n[11:8], n[11:8]};
					blue_d  = {n[7:4], n[7:4]};
					alpha_d = {n[3:0], n[3:0]};
				end
				LEN_RRGGBB: begin
					red_d   = n[23:16];
					green_d = n[15:8];
					blue_d  = n[7:0];
					alpha_d = ALPHA_DEFAULT;
				end
				LEN_RRGGBBAA: begin
					red_d   = n[31:24];
					green_d = n[23:16];
					blue_d  = n[15:8];
					alpha_d = n[7:0];
				end
				default: status_d = ST_FORMAT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_d;
			red_q    <= red_d;
			green_q  <= green_d;
			blue_q   <= blue_d;
			alpha_q  <= alpha_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign alpha     = alpha_q;

	`HCLP_ASSERT(a_error_zero_channels,
		(out_valid_q && status_q != ST_OK) |->
		(red_q == '0 && green_q == '0 && blue_q == '0 && alpha_q == '0))

endmodule

`default_nettype wire

### rtl/core/hex_color_literal_parser_top.sv
// Hex color literal parser, top level: front end, record queue, back end.
// Depends on hclp_pkg, hclp_front, hclp_queue, hclp_back.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one character per transfer:
//   char_code, has_char (0 for a bare end marker) and last (end of string).
//   Output channel (out_valid/out_stall) carries one result per string:
//   status (0 ok, 1 empty, 2 unsupported format, 3 invalid character) and
//   red, green, blue, alpha. Channels are zero on any error status.
//   Throughput: one character per cycle while in_stall is low. The front end
//   updates the scan state in the cycle of the transfer; no per-character loop
//   limits it. After the transfer marked last, the record is written into the
//   queue, then formatted into the output register once that register is free.
//   A two-entry queue sits between front and back; when the receiver stalls,
//   up to two finished strings plus the held result are buffered, and only
//   then is in_stall raised. in_stall is high exactly when the queue is full.
//   Reset (arst_n low) clears the scan state, empties the queue and drops
//   out_valid.
`default_nettype none

module hex_color_literal_parser_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic [hclp_pkg::CHAR_W-1:0] char_code,
	input  wire logic                        has_char,
	input  wire logic                        last,
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic [1:0]                  status,
	output      logic [hclp_pkg::CHAN_W-1:0] red,
	output      logic [hclp_pkg::CHAN_W-1:0] green,
	output      logic [hclp_pkg::CHAN_W-1:0] blue,
	output      logic [hclp_pkg::CHAN_W-1:0] alpha
);
	import hclp_pkg::*;

	logic      push, full, pop, empty;
	scan_rec_t push_rec, pop_rec;

	hclp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.has_char  (has_char),
		.last      (last),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full)
	);

	hclp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	hclp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_rec   (pop_rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha)
	);

endmodule

`default_nettype wire

### sim/hex_color_literal_parser_top_tb.sv
// Testbench for hex_color_literal_parser_top: directed and random color literals,
// checked against an in-bench predictor of the parse. Depends on hclp_pkg and the RTL.
module hex_color_literal_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hclp_pkg::*;

	localparam int RANDOM_CHARS = 1050;
	localparam int MAX_PAUSE    = 18;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              has;
		logic              lst;
	} char_item_t;

	typedef struct {
		status_t           status;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} color_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	char_item_t tx_item = '{8'd0, 1'b0, 1'b0};
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [CHAN_W-1:0] red, green, blue, alpha;

	hex_color_literal_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (tx_item.code),
		.has_char  (tx_item.has),
		.last      (tx_item.lst),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha)
	);

	always #5 clk = ~clk;

	char_item_t char_queue[$];
	color_t     expected_colors[$];
	int         total_chars = 0;
	int         chars_taken = 0;
	int         fail_count = 0;
	int         idle_cycles = 0;
	logic       in_took = 1'b0;
	logic       out_took = 1'b0;
	logic       hold_out = 1'b0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;
	int         tx_wait = 0;
	int         rx_wait = 0;

	// scan state of the string in progress
	phase_t              scan_phase = PH_LEAD;
	logic [COUNT_W-1:0]  scan_count = '0;
	logic [NIB_W-1:0]    scan_store = '0;
	logic                scan_bad = 1'b0;

	function automatic bit ws_char(input logic [CHAR_W-1:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// 16 marks a byte that is not a hex digit
	function automatic logic [4:0] nibble_of(input logic [CHAR_W-1:0] c);
		if (c >= "0" && c <= "9")
			return 5'(c - "0");
		if (c >= "A" && c <= "F")
			return 5'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f")
			return 5'(c - "a" + 8'd10);
		return 5'd16;
	endfunction

	function automatic logic [3:0] store_nib(input int idx);
		logic [NIB_W-1:0] t;
		t = scan_store >> (4 * (int'(scan_count) - 1 - idx));
		return t[3:0];
	endfunction

	// Advance the scan by one character; returns 1 when a result is due.
	function automatic bit predict_color(input char_item_t it, output color_t res);
		logic [4:0] v;
		res = '{ST_OK, 8'd0, 8'd0, 8'd0, 8'd0};
		if (it.has) begin
			if (scan_phase == PH_LEAD) begin
				if (!ws_char(it.code))
					scan_phase = (it.code == HASH_CHAR) ? PH_TOKEN : PH_NOTSH;
			end else if (scan_phase == PH_TOKEN) begin
				if (ws_char(it.code)) begin
					scan_phase = PH_AFTER;
				end else begin
					v = nibble_of(it.code);
					if (v[4])
						scan_bad = 1'b1;
					else
						scan_store = {scan_store[NIB_W-5:0], v[3:0]};
					if (scan_count != DIGITS_MAX)
						scan_count = scan_count + 1'b1;
				end
			end
		end
		if (!it.lst)
			return 1'b0;
		if (scan_phase == PH_LEAD) begin
			res.status = ST_EMPTY;
		end else if (scan_phase == PH_NOTSH) begin
			res.status = ST_FORMAT;
		end else if (scan_bad) begin
			res.status = ST_BADCHAR;
		end else if (scan_count == LEN_RGB || scan_count == LEN_RGBA) begin
			// nibble times 17 is the nibble repeated
			res.red   = {store_nib(0), store_nib(0)};
			res.green = {store_nib(1), store_nib(1)};
			res.blue  = {store_nib(2), store_nib(2)};
			res.alpha = (scan_count == LEN_RGBA) ?
				{store_nib(3), store_nib(3)} : ALPHA_DEFAULT;
		end else if (scan_count == LEN_RRGGBB || scan_count == LEN_RRGGBBAA) begin
			res.red   = {store_nib(0), store_nib(1)};
			res.green = {store_nib(2), store_nib(3)};
			res.blue  = {store_nib(4), store_nib(5)};
			res.alpha = (scan_count == LEN_RRGGBBAA) ?
				{store_nib(6), store_nib(7)} : ALPHA_DEFAULT;
		end else begin
			res.status = ST_FORMAT;
		end
		scan_phase = PH_LEAD;
		scan_count = '0;
		scan_store = '0;
		scan_bad = 1'b0;
		return 1'b1;
	endfunction

	task automatic push_char(input logic [CHAR_W-1:0] c, input logic lst);
		char_queue.push_back('{c, 1'b1, lst});
	endtask

	// end marker without a character; the code byte is don't-care
	task automatic push_marker(input logic lst);
		char_queue.push_back('{CHAR_W'($urandom_range(0, 255)), 1'b0, lst});
	endtask

	function automatic logic [CHAR_W-1:0] rand_space();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? 8'd32 : CHAR_W'(9 + k);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_hex();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10)
			return CHAR_W'("0" + k);
		if (k < 16)
			return CHAR_W'("a" + k - 10);
		return CHAR_W'("A" + k - 16);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_junk();
		logic [CHAR_W-1:0] c;
		logic [4:0]        v;
		do begin
			c = CHAR_W'($urandom_range(0, 255));
			v = nibble_of(c);
		end while (ws_char(c) || !v[4]);
		return c;
	endfunction

	task automatic add_random_string();
		logic [CHAR_W-1:0] s[$];
		int kind, len;
		bit bare_end;
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) s.push_back(rand_space());
			s.push_back(HASH_CHAR);
			case ($urandom_range(0, 3))
				0: len = 3;
				1: len = 4;
				2: len = 6;
				default: len = 8;
			endcase
			repeat (len) s.push_back(rand_hex());
			if (kind == 7)
				s[s.size() - $urandom_range(1, len)] = rand_junk();
			// trailing whitespace, then anything
			if ($urandom_range(0, 2) == 0) begin
				s.push_back(rand_space());
				repeat ($urandom_range(0, 3)) s.push_back(CHAR_W'($urandom_range(0, 255)));
			end
		end else if (kind == 8) begin
			s.push_back(HASH_CHAR);
			repeat ($urandom_range(0, 20)) s.push_back(rand_hex());
		end else begin
			repeat ($urandom_range(0, 6))
				s.push_back($urandom_range(0, 1) ? rand_space() :
					CHAR_W'($urandom_range(0, 255)));
		end
		bare_end = (s.size() == 0) || ($urandom_range(0, 7) == 0);
		foreach (s[k]) begin
			if ($urandom_range(0, 24) == 0)
				push_marker(1'b0);
			push_char(s[k], !bare_end && k == s.size() - 1);
		end
		if (bare_end)
			push_marker(1'b1);
	endtask

	// sender: one pause drawn per item, calm stretches toggle now and then
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (tx_wait != 0) begin
				tx_wait <= tx_wait - 1;
				in_valid <= 1'b0;
			end else if (char_queue.size() != 0) begin
				tx_item <= char_queue.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					tx_calm = !tx_calm;
				tx_wait <= tx_calm ? 0 : $urandom_range(0, MAX_PAUSE);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall each result for a drawn number of cycles
	always @(negedge clk) begin
		int w;
		w = rx_wait;
		if (out_took) begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			w = rx_calm ? 0 : $urandom_range(0, MAX_PAUSE);
		end else if (out_valid && w != 0) begin
			w = w - 1;
		end
		rx_wait <= w;
		out_stall <= arst_n && (hold_out || w != 0);
	end

	always @(posedge clk) begin
		color_t want;
		color_t seen;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			out_took <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				if (predict_color(tx_item, want))
					expected_colors.push_back(want);
				chars_taken <= chars_taken + 1;
			end
			if (out_valid && !out_stall) begin
				seen = '{status_t'(status), red, green, blue, alpha};
				if (expected_colors.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d rgba %h %h %h %h",
							status, red, green, blue, alpha);
				end else begin
					want = expected_colors.pop_front();
					if (seen.status !== want.status || seen.red !== want.red ||
							seen.green !== want.green || seen.blue !== want.blue ||
							seen.alpha !== want.alpha) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch at %0t: exp status %0d rgba %h %h %h %h,",
								" got status %0d rgba %h %h %h %h"},
								$realtime, want.status, want.red, want.green,
								want.blue, want.alpha, status, red, green, blue,
								alpha);
					end
				end
			end
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// long receiver hold-offs so the result queue fills and input backs up
	initial begin
		int marks[2];
		marks = '{300, 800};
		foreach (marks[k]) begin
			wait (chars_taken >= marks[k]);
			hold_out = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_out = 1'b0;
		end
	end

	initial begin
		int directed_n;
		// empty strings: bare end marker, then whitespace only
		push_marker(1'b1);
		push_char(8'd9, 1'b0);
		push_char(8'd12, 1'b1);
		// short forms
		push_char(HASH_CHAR, 1'b0);
		push_char("f", 1'b0);
		push_char("F", 1'b0);
		push_char("f", 1'b1);
		push_char(HASH_CHAR, 1'b0);
		push_char("0", 1'b0);
		push_char("a", 1'b0);
		push_char("9", 1'b0);
		push_char("F", 1'b1);
		// long form with a mid-string end marker that adds nothing
		push_char(HASH_CHAR, 1'b0);
		push_char("F", 1'b0);
		push_char("0", 1'b0);
		push_marker(1'b0);
		push_char("e", 1'b0);
		push_char("1", 1'b0);
		push_char("D", 1'b0);
		push_char("2", 1'b1);
		// first character not '#', then a high byte as first character
		push_char("x", 1'b1);
		push_char(8'h80, 1'b1);
		// invalid characters in the token
		push_char(HASH_CHAR, 1'b0);
		push_char("g", 1'b1);
		push_char(HASH_CHAR, 1'b0);
		push_char(8'hFF, 1'b1);
		// no digits at all
		push_char(HASH_CHAR, 1'b1);
		directed_n = char_queue.size();
		while (char_queue.size() < directed_n + RANDOM_CHARS)
			add_random_string();
		total_chars = char_queue.size();

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		wait (chars_taken == total_chars);
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hclp_pkg.sv
rtl/core/hclp_front.sv
rtl/core/hclp_queue.sv
rtl/core/hclp_back.sv
rtl/core/hex_color_literal_parser_top.sv
sim/hex_color_literal_parser_top_tb.sv
